### rtl/line_clip_window_top_assert.svh
// Assertion macros for the line clipping window block.
`ifndef LINE_CLIP_WINDOW_TOP_ASSERT_SVH
`define LINE_CLIP_WINDOW_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LCW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("line_clip_window check failed");
`define LCW_ASSERT_DIS(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("line_clip_window check failed");
`else
`define LCW_ASSERT(label, prop)
`define LCW_ASSERT_DIS(label, prop)
`endif
`endif

### rtl/lcw_pkg.sv
// Shared constants of the line clipping window block.
package lcw_pkg;

  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  localparam int X_MIN_RESET = 200;
  localparam int Y_MIN_RESET = 300;
  localparam int X_MAX_RESET = 700;
  localparam int Y_MAX_RESET = 750;

endpackage

### rtl/line_clip_window_top.sv
// Top level: Liang-Barsky clipping of a 2D segment against a configurable window.
//
//   channel | signals                                   | role
//   in      | in_valid/in_ready, start_x..end_y         | segment endpoints
//   out     | out_valid/out_ready, visible..end_cut     | clipped segment
//   cfg     | cfg_we, cfg_index, cfg_data               | window edge registers
//
// One segment is taken every cycle while the output is not stalled; the pipeline depth
// is set by the four dividers producing one quotient bit per stage.
// Reset clears all valid bits and loads the window registers with their defaults.
// A stall on the output freezes the whole pipeline; nothing moves until the
// waiting result has been taken, so no transfer is lost or repeated.
module line_clip_window_top #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  visible,
  output logic [COORD_BITS-1:0] out_start_x,
  output logic [COORD_BITS-1:0] out_start_y,
  output logic [COORD_BITS-1:0] out_end_x,
  output logic [COORD_BITS-1:0] out_end_y,
  output logic                  start_cut,
  output logic                  end_cut
);

  localparam int CW = COORD_BITS;
  localparam int FW = FRAC_BITS;
  localparam int NW = CW + FW;
  localparam int RW = NW + 1;
  localparam int PW = FW + CW + 3;
  localparam logic signed [RW-1:0] U_ONE  = {{(RW-1){1'b0}}, 1'b1} << FW;
  localparam logic signed [RW-1:0] U_ZERO = '0;
  localparam logic signed [PW-1:0] HALF   = {{(PW-1){1'b0}}, 1'b1} << (FW - 1);

  typedef struct packed {
    logic [CW-1:0]        x1;
    logic [CW-1:0]        y1;
    logic [CW-1:0]        x2;
    logic [CW-1:0]        y2;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic                 ok;
    logic [3:0]           neg;
  } side_t;

  // Window registers.
  logic [CW-1:0] win_x_min, win_y_min, win_x_max, win_y_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_x_min <= CW'(lcw_pkg::X_MIN_RESET);
      win_y_min <= CW'(lcw_pkg::Y_MIN_RESET);
      win_x_max <= CW'(lcw_pkg::X_MAX_RESET);
      win_y_max <= CW'(lcw_pkg::Y_MAX_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        lcw_pkg::REG_X_MIN: win_x_min <= cfg_data;
        lcw_pkg::REG_Y_MIN: win_y_min <= cfg_data;
        lcw_pkg::REG_X_MAX: win_x_max <= cfg_data;
        lcw_pkg::REG_Y_MAX: win_y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !rst;

  // Stage 0: edge tests.
  logic signed [CW:0] dx_c, dy_c;
  logic signed [CW:0] q_c [4];
  logic [CW:0]        adx_w, ady_w;
  logic [CW:0]        aq_w [4];
  logic [3:0]         pneg_c;
  logic               ok_c;

  assign dx_c   = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
  assign dy_c   = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
  assign q_c[0] = $signed({1'b0, start_x}) - $signed({1'b0, win_x_min});
  assign q_c[1] = $signed({1'b0, win_x_max}) - $signed({1'b0, start_x});
  assign q_c[2] = $signed({1'b0, start_y}) - $signed({1'b0, win_y_min});
  assign q_c[3] = $signed({1'b0, win_y_max}) - $signed({1'b0, start_y});
  assign adx_w  = dx_c[CW] ? -dx_c : dx_c;
  assign ady_w  = dy_c[CW] ? -dy_c : dy_c;
  assign pneg_c = {dy_c < 0, dy_c > 0, dx_c < 0, dx_c > 0};

  for (genvar i = 0; i < 4; i++) begin : g_q
    assign aq_w[i] = q_c[i][CW] ? -q_c[i] : q_c[i];
  end

  // A segment parallel to an edge and outside it is marked as rejected.
  assign ok_c = !((dx_c == 0) && (q_c[0][CW] || q_c[1][CW])) &&
                !((dy_c == 0) && (q_c[2][CW] || q_c[3][CW]));

  logic          v0;
  side_t         s0_side;
  logic [CW-1:0] s0_qm [4];
  logic [CW-1:0] s0_adx, s0_ady;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side.x1  <= start_x;
      s0_side.y1  <= start_y;
      s0_side.x2  <= end_x;
      s0_side.y2  <= end_y;
      s0_side.dx  <= dx_c;
      s0_side.dy  <= dy_c;
      s0_side.ok  <= ok_c;
      s0_side.neg <= {q_c[3][CW] ^ pneg_c[3], q_c[2][CW] ^ pneg_c[2],
                      q_c[1][CW] ^ pneg_c[1], q_c[0][CW] ^ pneg_c[0]};
      for (int i = 0; i < 4; i++) begin
        s0_qm[i] <= aq_w[i][CW-1:0];
      end
      s0_adx <= adx_w[CW-1:0];
      s0_ady <= ady_w[CW-1:0];
    end
  end

  // Dividers: |q| * 2^FW / |p| for each edge.
  logic [NW-1:0] quo [4];

  for (genvar i = 0; i < 4; i++) begin : g_div
    lcw_div #(.NUM_W(NW), .DEN_W(CW)) u_div (
      .clk (clk),
      .en  (adv),
      .num ({s0_qm[i], {FW{1'b0}}}),
      .den ((i < 2) ? s0_adx : s0_ady),
      .quo (quo[i])
    );
  end

  side_t side_pipe [NW];
  logic  vd [NW];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_pipe[0] <= s0_side;
      for (int k = 1; k < NW; k++) begin
        side_pipe[k] <= side_pipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NW; k++) begin
        vd[k] <= 1'b0;
      end
    end else if (adv) begin
      vd[0] <= v0;
      for (int k = 1; k < NW; k++) begin
        vd[k] <= vd[k-1];
      end
    end
  end

  // Stage 1: entry and exit parameters.
  side_t               sd;
  logic signed [RW-1:0] r_c [4];
  logic signed [RW-1:0] u1x, u1y, u2x, u2y, u1m, u2m;

  assign sd = side_pipe[NW-1];

  for (genvar i = 0; i < 4; i++) begin : g_r
    assign r_c[i] = sd.neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
  end

  // For dx > 0 the left edge is the entry and the right edge the exit, and the
  // other way round for dx < 0; the same holds for bottom and top with dy.
  assign u1x = (sd.dx > 0) ? r_c[0] : ((sd.dx < 0) ? r_c[1] : U_ZERO);
  assign u2x = (sd.dx > 0) ? r_c[1] : ((sd.dx < 0) ? r_c[0] : U_ONE);
  assign u1y = (sd.dy > 0) ? r_c[2] : ((sd.dy < 0) ? r_c[3] : U_ZERO);
  assign u2y = (sd.dy > 0) ? r_c[3] : ((sd.dy < 0) ? r_c[2] : U_ONE);
  assign u1m = (u1x > u1y) ? u1x : u1y;
  assign u2m = (u2x < u2y) ? u2x : u2y;

  logic                 v1;
  side_t                s1_side;
  logic signed [RW-1:0] s1_u1, s1_u2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= vd[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side <= sd;
      s1_u1   <= u1m[RW-1] ? U_ZERO : u1m;
      s1_u2   <= (u2m > U_ONE) ? U_ONE : u2m;
    end
  end

  // Stage 2: reject decision and products u * d.
  logic signed [FW+1:0] u1s, u2s;
  logic signed [PW-1:0] m_sx, m_sy, m_ex, m_ey;

  assign u1s  = $signed({1'b0, s1_u1[FW:0]});
  assign u2s  = $signed({1'b0, s1_u2[FW:0]});
  assign m_sx = u1s * s1_side.dx;
  assign m_sy = u1s * s1_side.dy;
  assign m_ex = u2s * s1_side.dx;
  assign m_ey = u2s * s1_side.dy;

  logic                 v2;
  logic                 s2_reject, s2_scut, s2_ecut;
  logic [CW-1:0]        s2_x1, s2_y1, s2_x2, s2_y2;
  logic signed [PW-1:0] s2_sx, s2_sy, s2_ex, s2_ey;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_reject <= !s1_side.ok || (s1_u1 > s1_u2);
      s2_scut   <= s1_u1 > U_ZERO;
      s2_ecut   <= s1_u2 < U_ONE;
      s2_x1     <= s1_side.x1;
      s2_y1     <= s1_side.y1;
      s2_x2     <= s1_side.x2;
      s2_y2     <= s1_side.y2;
      s2_sx     <= m_sx;
      s2_sy     <= m_sy;
      s2_ex     <= m_ex;
      s2_ey     <= m_ey;
    end
  end

  // Stage 3: rounding, saturation and output register.
  function automatic logic [CW-1:0] round_sat(input logic [CW-1:0] base,
                                              input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] v;
    logic signed [PW-1:0] rnd;
    logic [PW-FW-1:0]     hi;
    v   = $signed({3'b000, base, {FW{1'b0}}}) + prod;
    rnd = v + HALF;
    hi  = rnd[PW-1:FW];
    if (v[PW-1]) begin
      round_sat = '0;
    end else if (|hi[PW-FW-1:CW]) begin
      round_sat = '1;
    end else begin
      round_sat = hi[CW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      visible     <= !s2_reject;
      out_start_x <= s2_reject ? s2_x1 : round_sat(s2_x1, s2_sx);
      out_start_y <= s2_reject ? s2_y1 : round_sat(s2_y1, s2_sy);
      out_end_x   <= s2_reject ? s2_x2 : round_sat(s2_x1, s2_ex);
      out_end_y   <= s2_reject ? s2_y2 : round_sat(s2_y1, s2_ey);
      start_cut   <= !s2_reject && s2_scut;
      end_cut     <= !s2_reject && s2_ecut;
    end
  end

`include "line_clip_window_top_assert.svh"

  `LCW_ASSERT(a_reset_flush, rst |=> !out_valid && !v0 && !v1 && !v2)
  `LCW_ASSERT_DIS(a_reject_no_cut, out_valid && !visible |-> !start_cut && !end_cut)
  `LCW_ASSERT_DIS(a_hold_on_stall, !adv |=> $stable(v1) && $stable(v2) && $stable(v0))

endmodule

### rtl/lcw_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module lcw_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] a_num;
    logic [DEN_W-1:0] a_rem;
    logic [DEN_W-1:0] a_den;
    logic [NUM_W-1:0] a_quo;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign a_num = num;
      assign a_rem = '0;
      assign a_den = den;
      assign a_quo = '0;
    end else begin : g_next
      assign a_num = num_r[k-1];
      assign a_rem = rem_r[k-1];
      assign a_den = den_r[k-1];
      assign a_quo = quo_r[k-1];
    end

    assign sh   = {a_rem, a_num[NUM_W-1]};
    assign diff = sh - {1'b0, a_den};
    assign ge   = (sh >= {1'b0, a_den});

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= a_num << 1;
        rem_r[k] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        den_r[k] <= a_den;
        quo_r[k] <= {a_quo[NUM_W-2:0], ge};
      end
    end
  end

  assign quo = quo_r[NUM_W-1];

endmodule
